// File: src/bba_pkg.sv
// Shared types and codes for the bitmap block allocator.
// No dependencies; used by block_bitmap_allocator_core.
package bba_pkg;

  localparam int unsigned BLOCK_W  = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [BLOCK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] allocated_block;
    status_t            status;
  } rsp_t;

endpackage

// File: src/block_bitmap_allocator_core.sv
// First-fit bitmap block allocator: one RAM word scanned per cycle.
// Each item examines 1 to MAP_WORDS words, and no new item is taken until it is done;
// the scan rate is bounded by the single RAM read port feeding the shared word-check unit.
// A result register lets the next item enter while a result still waits.
// Synchronous reset sets total_blocks to 4096, then a clearing pass writes
// every one of the MAP_WORDS bitmap words (128 by default) to zero; no item is taken meanwhile.
// Depends on bba_pkg and bba_ram.
module block_bitmap_allocator_core #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned WORD_BITS  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  bba_pkg::req_t                  req,
  // response channel
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output bba_pkg::rsp_t                  rsp,
  // configuration: total_blocks
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bba_pkg::COUNT_W-1:0]    cfg_data
);

  // Bitmap geometry: bit (n mod WORD_BITS) of word (n / WORD_BITS) is block n.
  localparam int unsigned MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned OW  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  // Count width: holds the limit, the block number and a word base past the end.
  localparam int unsigned BW0 = $clog2(MAX_BLOCKS + WORD_BITS + 1);
  localparam int unsigned CW  = (BW0 > bba_pkg::COUNT_W) ? BW0 : bba_pkg::COUNT_W;

  // Registers
  bba_pkg::state_t                  state, state_next;
  logic [AW-1:0]                    word_idx, word_idx_next;
  logic [CW-1:0]                    base, base_next;   // block number of bit 0 of word_idx
  bba_pkg::op_t                     op;
  logic [bba_pkg::BLOCK_W-1:0]      blk;
  logic [bba_pkg::COUNT_W-1:0]      total_blocks;
  logic                             rsp_valid_next;
  bba_pkg::rsp_t                    rsp_next;

  // RAM port signals
  logic                             wr_en;
  logic [AW-1:0]                    rd_addr;
  logic [WORD_BITS-1:0]             wr_data;
  logic [WORD_BITS-1:0]             rd_data;

  // Word-check unit
  logic [CW-1:0]                    limit;
  logic [CW-1:0]                    rem;        // blocks left below the limit from base
  logic [CW-1:0]                    base_end;   // first block of the next word
  logic [CW-1:0]                    blk_ext;
  logic [WORD_BITS-1:0]             avail;      // free bits below the limit
  logic                             found;
  logic [OW-1:0]                    hit_idx;
  logic [OW-1:0]                    off;
  logic                             last_word;
  logic                             blk_here;
  logic                             out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_blocks <= bba_pkg::COUNT_W'(4096);
    end else if (cfg_valid && cfg_ready) begin
      total_blocks <= cfg_data;
    end
  end

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (word_idx),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Saturate the configured count at the bitmap size.
  always_comb begin
    if (CW'(total_blocks) > CW'(MAX_BLOCKS)) begin
      limit = CW'(MAX_BLOCKS);
    end else begin
      limit = CW'(total_blocks);
    end
  end

  assign rem       = limit - base;
  assign base_end  = base + CW'(WORD_BITS);
  assign last_word = (base_end >= limit);
  assign blk_ext   = CW'(blk);
  assign blk_here  = (blk_ext < base_end);
  assign off       = OW'(blk_ext - base);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Lowest free bit of the current word, masked at the block limit.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = !rd_data[i] && (CW'(i) < rem);
    end
    found   = |avail;
    hit_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_idx = OW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::FSM_CLEAR;
      word_idx  <= '0;
      base      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      word_idx  <= word_idx_next;
      base      <= base_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Item and result payload: no reset needed.
  always_ff @(posedge clk) begin
    if (state == bba_pkg::FSM_IDLE && req_valid) begin
      op  <= req.operation;
      blk <= req.block_number;
    end
    rsp <= rsp_next;
  end

  always_comb begin
    logic done;
    state_next     = state;
    word_idx_next  = word_idx;
    base_next      = base;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;
    req_stall      = 1'b1;
    wr_en          = 1'b0;
    wr_data        = '0;
    rd_addr        = word_idx;
    done           = 1'b0;

    unique case (state)
      bba_pkg::FSM_CLEAR: begin
        // Sweep the bitmap to all free, one word a cycle.
        wr_en = 1'b1;
        if (word_idx == AW'(MAP_WORDS - 1)) begin
          word_idx_next = '0;
          state_next    = bba_pkg::FSM_IDLE;
        end else begin
          word_idx_next = word_idx + AW'(1);
        end
      end

      bba_pkg::FSM_IDLE: begin
        // Both operations walk up from word 0; issue its read now.
        req_stall = 1'b0;
        rd_addr   = '0;
        if (req_valid) begin
          word_idx_next = '0;
          base_next     = '0;
          state_next    = bba_pkg::FSM_SCAN;
        end
      end

      bba_pkg::FSM_SCAN: begin
        rsp_next.allocated_block = '0;
        rsp_next.status          = bba_pkg::ST_OK;
        if (op == bba_pkg::OP_ALLOC) begin
          if (found) begin
            done    = 1'b1;
            wr_data = rd_data | (WORD_BITS'(1) << hit_idx);
            wr_en   = out_free;
            rsp_next.allocated_block = bba_pkg::BLOCK_W'(base + CW'(hit_idx));
          end else if (last_word) begin
            done            = 1'b1;
            rsp_next.status = bba_pkg::ST_FULL;
          end
        end else begin
          if (blk_ext >= limit) begin
            done            = 1'b1;
            rsp_next.status = bba_pkg::ST_RANGE;
          end else if (blk_here) begin
            done = 1'b1;
            if (!rd_data[off]) begin
              rsp_next.status = bba_pkg::ST_ALREADY_FREE;
            end else begin
              wr_data = rd_data & ~(WORD_BITS'(1) << off);
              wr_en   = out_free;
            end
          end
        end

        if (done) begin
          // Commit only when the result register can take the item; else hold
          // and keep rereading the same word.
          if (out_free) begin
            rsp_valid_next = 1'b1;
            state_next     = bba_pkg::FSM_IDLE;
          end else begin
            rsp_next = rsp;
          end
        end else begin
          // Advance to the next word; hold any waiting result.
          rsp_next      = rsp;
          word_idx_next = word_idx + AW'(1);
          base_next     = base_end;
          rd_addr       = word_idx + AW'(1);
        end
      end

      default: begin
        state_next = bba_pkg::FSM_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A failed request never reports a block number.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != bba_pkg::ST_OK) |-> rsp.allocated_block == '0)
    else $error("nonzero block reported with failure status");

  // The scan never walks past the last bitmap word.
  a_scan_in_map: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::FSM_SCAN) |-> (int'(word_idx) < int'(MAP_WORDS)))
    else $error("scan ran past the bitmap");

  // The bitmap is written only by the clearing pass or a committing scan.
  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != bba_pkg::FSM_IDLE))
    else $error("bitmap written while idle");

  // A new result is loaded only on the cycle a scan finishes.
  a_result_from_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == bba_pkg::FSM_SCAN)
    else $error("result appeared without a scan");
`endif

endmodule

// File: src/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the usage bitmap words.
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
